>>> src/xsde_pkg.sv
// xsde_pkg: shared types and constants for the XOR sprite display engine.
// No dependencies.
package xsde_pkg;

  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_ROWS    = 64;
  localparam int ROW_WORDS      = SCREEN_COLUMNS / 64;
  localparam int ROW_BITS       = $clog2(SCREEN_ROWS);
  localparam int ADDR_BITS      = 1 + ROW_BITS + 1;
  localparam int STORE_DEPTH    = 2 * SCREEN_ROWS * ROW_WORDS;

  localparam logic [2:0] KIND_DRAW   = 3'd0;
  localparam logic [2:0] KIND_SCR_R  = 3'd1;
  localparam logic [2:0] KIND_SCR_L  = 3'd2;
  localparam logic [2:0] KIND_SCR_D  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;
  localparam logic [2:0] KIND_WRITE  = 3'd5;

  // one queued command, as unpacked from the s_axis item
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  planes;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  row_index;
    logic [15:0] pattern;
    logic        wide;
    logic        low_res;
    logic        first_row;
    logic [3:0]  scroll_rows;
    logic [2:0]  word_index;
    logic        plane_select;
  } cmd_t;

  typedef struct packed {
    logic        collision;
    logic [15:0] read_data;
  } res_t;

endpackage

>>> src/xsde_front.sv
// xsde_front: input stage and two-entry command queue.
// Depends on xsde_pkg.
module xsde_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  xsde_pkg::cmd_t in_cmd,
  output logic           q_valid,
  input  logic           q_ready,
  output xsde_pkg::cmd_t q_cmd
);

  xsde_pkg::cmd_t slot [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

>>> src/xsde_back.sv
// xsde_back: executes commands against the frame store (one 64-bit word per
// address, read-modify-write sequencer). Depends on xsde_pkg.
module xsde_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  xsde_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output xsde_pkg::res_t out_res
);

  localparam int AB = xsde_pkg::ADDR_BITS;
  localparam int RB = xsde_pkg::ROW_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [63:0] mem [xsde_pkg::STORE_DEPTH];
  logic [63:0] rdata;
  logic [AB-1:0] raddr;
  logic [AB-1:0] waddr;
  logic [63:0]   wdata;
  logic          wen;

  logic [2:0]    state;
  logic [2:0]    state_next;
  xsde_pkg::cmd_t cur;
  // step walks (plane, row, sub) combinations
  logic          plane;
  logic [RB-1:0] row;
  logic [1:0]    sub;     // draw: line (bit1) and word (bit0); scroll: word
  logic [63:0]   w0;      // saved left word for right scroll
  logic [63:0]   w1;
  logic          collided;
  logic [15:0]   rd_word;
  logic [AB-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // draw geometry
  logic [7:0]   ox;
  logic [RB-1:0] oy;
  logic [31:0]  spr;      // expanded sprite pixels, MSB leftmost
  logic [5:0]   span;
  logic [127:0] mask_line;
  logic [RB-1:0] draw_row;
  logic [RB-1:0] down_src;
  logic [RB-1:0] cur_row;

  always_comb begin
    logic [15:0] b;
    logic [31:0] d;
    b = cur.wide ? cur.pattern : {cur.pattern[15:8], 8'h00};
    for (int i = 0; i < 16; i++) d[2*i +: 2] = {2{b[i]}};
    if (cur.low_res) begin
      ox   = {1'b0, cur.x[5:0], 1'b0};
      oy   = {cur.y[RB-2:0], 1'b0};
      spr  = d;
      span = cur.wide ? 6'd32 : 6'd16;
    end else begin
      ox   = {1'b0, cur.x[6:0]};
      oy   = cur.y[RB-1:0];
      spr  = {b, 16'h0000};
      span = cur.wide ? 6'd16 : 6'd8;
    end
  end

  always_comb begin
    logic [255:0] ext;
    logic [255:0] rot;
    ext = {spr, 224'd0};
    rot = ext >> ox;
    mask_line = rot[255:128] | rot[127:0];
    if (span == 6'd0) mask_line = '0;
  end

  assign cur_row  = row;
  assign draw_row = cur.low_res ? (oy + RB'({cur.row_index, 1'b0}) + RB'(sub[1]))
                                : (oy + RB'(cur.row_index));
  assign down_src = cur_row - RB'(cur.scroll_rows);

  logic plane_on;
  assign plane_on = cur.planes[plane];

  always_comb begin
    raddr = '0;
    case (cur.kind)
      xsde_pkg::KIND_DRAW: raddr = {plane, draw_row, sub[0]};
      xsde_pkg::KIND_SCR_D: raddr = {plane, down_src, sub[0]};
      xsde_pkg::KIND_READ, xsde_pkg::KIND_WRITE:
        raddr = {cur.plane_select, cur.y[RB-1:0], cur.word_index[2]};
      default: raddr = {plane, cur_row, sub[0]};
    endcase
  end

  // write data
  logic [63:0] dmask;
  logic        wr_active;
  always_comb begin
    logic [63:0] sh;
    dmask = sub[0] ? mask_line[63:0] : mask_line[127:64];
    sh = 64'h0;
    wdata = rdata;
    wr_active = 1'b0;
    waddr = {plane, cur_row, sub[0]};
    case (cur.kind)
      xsde_pkg::KIND_DRAW: begin
        waddr = {plane, draw_row, sub[0]};
        wdata = rdata ^ dmask;
        wr_active = plane_on;
      end
      xsde_pkg::KIND_SCR_R: begin
        wdata = sub[0] ? {w0[3:0], rdata[63:4]} : {4'h0, rdata[63:4]};
        wr_active = plane_on;
      end
      xsde_pkg::KIND_SCR_L: begin
        wdata = sub[0] ? {rdata[59:0], 4'h0} : {rdata[59:0], w1[63:60]};
        wr_active = plane_on;
      end
      xsde_pkg::KIND_SCR_D: begin
        wdata = (cur_row >= RB'(cur.scroll_rows)) ? rdata : 64'h0;
        wr_active = plane_on;
      end
      xsde_pkg::KIND_WRITE: begin
        waddr = raddr;
        sh = {48'h0, cur.pattern} << (6'd48 - {cur.word_index[1:0], 4'h0});
        wdata = (rdata & ~(64'hFFFF << (6'd48 - {cur.word_index[1:0], 4'h0}))) | sh;
        wr_active = 1'b1;
      end
      default: ;
    endcase
    // clearing pass after reset: zero every address in turn
    if (state == S_CLEAR) begin
      waddr = clr_addr;
      wdata = 64'h0;
    end
  end

  assign wen = (state == S_CLEAR) || ((state == S_WRITE) && wr_active);

  // for sideways scroll, words are visited in order that lets neighbor data be
  // saved: right scroll visits word0 then word1 (w0 holds old word0), left
  // visits word1 then word0 (w1 holds old word1). Reads happen before writes.
  logic last_step;
  always_comb begin
    last_step = 1'b0;
    case (cur.kind)
      xsde_pkg::KIND_DRAW: last_step = plane && (sub == (cur.low_res ? 2'd3 : 2'd1));
      xsde_pkg::KIND_SCR_R, xsde_pkg::KIND_SCR_L:
        last_step = plane && (row[RB-1:0] == RB'(xsde_pkg::SCREEN_ROWS - 1)) &&
                    (sub[0] == (cur.kind == xsde_pkg::KIND_SCR_L ? 1'b0 : 1'b1));
      xsde_pkg::KIND_SCR_D: last_step = plane && (row[RB-1:0] == '0) && sub[0];
      default: last_step = 1'b1;
    endcase
  end

  assign cmd_ready = (state == S_DONE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == AB'(xsde_pkg::STORE_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (cmd_valid && !out_valid) state_next = S_READ;
      S_READ:  state_next = S_WAIT;
      S_WAIT:  state_next = S_WRITE;
      S_WRITE: state_next = last_step ? S_DONE : S_READ;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // the sequencer reads cmd directly (queue head is held until DONE)
  assign cur = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      collided  <= 1'b0;
      out_valid <= 1'b0;
      plane     <= 1'b0;
      row       <= '0;
      sub       <= 2'd0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AB'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_IDLE && cmd_valid && !out_valid) begin
        plane <= 1'b0;
        sub   <= (cmd.kind == xsde_pkg::KIND_SCR_L) ? 2'd1 : 2'd0;
        row   <= (cmd.kind == xsde_pkg::KIND_SCR_D) ? RB'(xsde_pkg::SCREEN_ROWS - 1)
                                                    : '0;
        if (cmd.kind == xsde_pkg::KIND_DRAW && cmd.first_row) collided <= 1'b0;
      end
      if (state == S_WRITE) begin
        if (cur.kind == xsde_pkg::KIND_DRAW && plane_on && |(rdata & dmask))
          collided <= 1'b1;
        if (cur.kind == xsde_pkg::KIND_SCR_R) w0 <= rdata;
        if (cur.kind == xsde_pkg::KIND_SCR_L) w1 <= rdata;
        if (cur.kind == xsde_pkg::KIND_READ) rd_word <= rdata[6'd48 - {cur.word_index[1:0], 4'h0} +: 16];
        // advance walk
        case (cur.kind)
          xsde_pkg::KIND_DRAW: begin
            if (sub == (cur.low_res ? 2'd3 : 2'd1)) begin
              sub <= 2'd0; plane <= 1'b1;
            end else sub <= sub + 2'd1;
          end
          xsde_pkg::KIND_SCR_R: begin
            sub[0] <= ~sub[0];
            if (sub[0]) begin
              if (row[RB-1:0] == RB'(xsde_pkg::SCREEN_ROWS - 1)) begin
                row <= '0; plane <= 1'b1;
              end else row <= row + RB'(1);
            end
          end
          xsde_pkg::KIND_SCR_L: begin
            sub[0] <= ~sub[0];
            if (!sub[0]) begin
              if (row[RB-1:0] == RB'(xsde_pkg::SCREEN_ROWS - 1)) begin
                row <= '0; plane <= 1'b1;
              end else row <= row + RB'(1);
            end
          end
          xsde_pkg::KIND_SCR_D: begin
            sub[0] <= ~sub[0];
            if (sub[0]) begin
              if (row[RB-1:0] == '0) begin
                row <= RB'(xsde_pkg::SCREEN_ROWS - 1); plane <= 1'b1;
              end else row <= row - RB'(1);
            end
          end
          default: ;
        endcase
      end
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end
      if (state == S_IDLE && cmd_valid && !out_valid && cmd.kind != xsde_pkg::KIND_READ)
        rd_word <= 16'h0;
    end
  end

  assign out_res.collision = collided;
  assign out_res.read_data = rd_word;

endmodule

>>> src/xor_sprite_display_engine.sv
// xor_sprite_display_engine: top level of the two-plane 128x64 XOR sprite
// framebuffer. Depends on xsde_pkg, xsde_front and xsde_back.
//
// Usage:
//  - s_axis carries one command word per item: tuser holds the kind (draw
//    row, scroll right/left, scroll down, read word, write word), tdata the
//    operands. m_axis returns exactly one result word per command: the
//    sprite collision flag and, for a read, the word.
//  - The frame store is one 64-bit word per address (2 planes x 64 rows x
//    2 words) with a registered read port; every command is run as
//    read / wait / write steps for each touched word. A read or write
//    word touches one word; a draw row touches 2 words per line and
//    plane; a sideways or down scroll walks 2 x 64 x 2 words.
//  - A two-entry queue takes commands while the engine is busy, so the
//    sender is stalled only when both entries are taken (the running one too).
//  - After rst a clearing pass zeroes all 256 words of the frame store; no
//    command runs until it finishes, but items may queue meanwhile.
//  - If the receiver holds m_axis_tready low, the result stays in its
//    output register and the engine stops before the next command.
module xor_sprite_display_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser, low bit up: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  // tdata, low bit up: planes[1:0], x[9:2], y[17:10], row_index[21:18],
  // pattern[37:22], wide[38], low_res[39], first_row[40],
  // scroll_rows[44:41], word_index[47:45], plane_select[48], zero fill
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low bit up: collision[0], read_data[16:1], zero fill
  output logic [23:0] m_axis_tdata
);

  xsde_pkg::cmd_t in_cmd;
  xsde_pkg::cmd_t q_cmd;
  xsde_pkg::res_t res;
  logic           q_valid;
  logic           q_ready;

  assign in_cmd.kind         = s_axis_tuser;
  assign in_cmd.planes       = s_axis_tdata[1:0];
  assign in_cmd.x            = s_axis_tdata[9:2];
  assign in_cmd.y            = s_axis_tdata[17:10];
  assign in_cmd.row_index    = s_axis_tdata[21:18];
  assign in_cmd.pattern      = s_axis_tdata[37:22];
  assign in_cmd.wide         = s_axis_tdata[38];
  assign in_cmd.low_res      = s_axis_tdata[39];
  assign in_cmd.first_row    = s_axis_tdata[40];
  assign in_cmd.scroll_rows  = s_axis_tdata[44:41];
  assign in_cmd.word_index   = s_axis_tdata[47:45];
  assign in_cmd.plane_select = s_axis_tdata[48];

  xsde_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  xsde_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {7'd0, res.read_data, res.collision};

endmodule
